### hdl/wtd_pkg.sv
// Shared types, constants and functions for the word table with dedup.
// Used by the cell, unit and checker modules; no dependencies of its own.
`timescale 1ns / 1ps

package wtd_pkg;

  localparam int DEPTH     = 64;
  localparam int KEY_BYTES = 8;
  localparam int KEY_W     = 64;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = 7;
  localparam int GRP_SIZE  = 8;
  localparam int GRP_W     = $clog2(GRP_SIZE);
  localparam int NUM_GRP   = DEPTH / GRP_SIZE;
  localparam int GSEL_W    = $clog2(NUM_GRP);
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_FIND  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE  = 3'd0,
    ST_MISS  = 3'd1,
    ST_DUP   = 3'd2,
    ST_FULL  = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_GRP  = 2'd1,
    S_SEL  = 2'd2
  } state_t;

  // Keep the bytes up to the first zero byte, drop the rest.
  function automatic key_t norm_key(key_t k);
    key_t r;
    logic live;
    r    = '0;
    live = 1'b1;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (k[8*i +: 8] == 8'd0) begin
        live = 1'b0;
      end
      if (live) begin
        r[8*i +: 8] = k[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

### hdl/wtd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
`timescale 1ns / 1ps

module wtd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

### hdl/wtd_cell.sv
// One table cell: holds a word, registers its compare result and passes
// the hit chain on to its neighbor. Depends on wtd_pkg.
`timescale 1ns / 1ps

module wtd_cell (
  input  logic          clk,
  input  logic          we,
  input  wtd_pkg::key_t wdata,
  input  logic          cmp_en,
  input  wtd_pkg::key_t key,
  input  logic          in_use,
  input  logic          hit_in,
  output logic          hit_out,
  output logic          first
);
  import wtd_pkg::*;

  key_t word_r;
  logic match_r;
  logic match_nxt;

  assign match_nxt = in_use && (key != '0) && (word_r == key);

  always_ff @(posedge clk) begin
    if (we) begin
      word_r <= wdata;
    end
    if (cmp_en) begin
      match_r <= match_nxt;
    end
  end

  assign hit_out = hit_in | match_r;
  assign first   = match_r & ~hit_in;

endmodule

### hdl/word_table_with_dedup_unit.sv
// Word table with duplicate check: a row of compare cells plus a read RAM.
// An accepted item goes through the registered compare, group encode and
// select steps to its result strobe; busy holds off a new item until the
// select step is done. Reset (rst_n low, synchronous) empties the table
// and sets capacity to 64; no clearing pass is needed. Results cannot stall.
`timescale 1ns / 1ps

module word_table_with_dedup_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_operation,
  input  logic [wtd_pkg::KEY_W-1:0]   in_key,
  input  logic                        in_check_duplicate,
  input  logic [wtd_pkg::IDX_W-1:0]   in_slot,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [wtd_pkg::IDX_W-1:0]   out_found_index,
  output logic [wtd_pkg::KEY_W-1:0]   out_word_out,
  output logic [wtd_pkg::CNT_W-1:0]   out_entry_count,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wtd_pkg::ADDR_W-1:0]  paddr,
  input  logic [wtd_pkg::DATA_W-1:0]  pwdata,
  output logic [wtd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import wtd_pkg::*;

  state_t state_r, state_nxt;
  cnt_t   fill_r, fill_nxt;
  cnt_t   cap_r;
  cnt_t   limit;

  op_t    op_r;
  key_t   key_r;
  logic   chk_r;
  idx_t   slot_r;
  key_t   key_n;
  logic   accept;

  logic [DEPTH-1:0] hit_in, hit_out, first;
  logic [DEPTH-1:0] cell_we;
  logic [NUM_GRP-1:0] grp_any_r;
  logic [GRP_W-1:0]   grp_idx_r [NUM_GRP];
  logic [NUM_GRP-1:0] grp_any_nxt;
  logic [GRP_W-1:0]   grp_idx_nxt [NUM_GRP];

  logic    hit_any;
  idx_t    hit_idx;
  key_t    ram_rdata;
  logic    wr_en;
  status_t res_status;
  idx_t    res_idx;
  key_t    res_word;

  logic    out_valid_r;
  status_t out_status_r;
  idx_t    out_idx_r;
  key_t    out_word_r;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = paddr[ADDR_W-1] ? '0 : DATA_W'(cap_r);
  assign limit  = (cap_r < cnt_t'(DEPTH)) ? cap_r : cnt_t'(DEPTH);

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign key_n  = norm_key(in_key);

  // Cell row, chained in groups of GRP_SIZE
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i % GRP_SIZE == 0) begin : g_head
      assign hit_in[i] = 1'b0;
    end else begin : g_link
      assign hit_in[i] = hit_out[i-1];
    end
    wtd_cell u_cell (
      .clk    (clk),
      .we     (cell_we[i]),
      .wdata  (key_r),
      .cmp_en (accept),
      .key    (key_n),
      .in_use (cnt_t'(i) < fill_r),
      .hit_in (hit_in[i]),
      .hit_out(hit_out[i]),
      .first  (first[i])
    );
    assign cell_we[i] = wr_en && (fill_r[IDX_W-1:0] == idx_t'(i));
  end

  wtd_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_ram (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (fill_r[IDX_W-1:0]),
    .wdata  (key_r),
    .re     (accept),
    .raddr  (in_slot),
    .rdata_r(ram_rdata)
  );

  // Per-group first-hit encode
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_any_nxt[g] = hit_out[g*GRP_SIZE + GRP_SIZE - 1];
      grp_idx_nxt[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (first[g*GRP_SIZE + j]) begin
          grp_idx_nxt[g] = grp_idx_nxt[g] | GRP_W'(j);
        end
      end
    end
  end

  // Lowest group with a hit wins
  always_comb begin
    hit_any = |grp_any_r;
    hit_idx = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        hit_idx = {GSEL_W'(g), grp_idx_r[g]};
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_GRP;
      S_GRP:   state_nxt = S_SEL;
      S_SEL:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result of the item in the select step
  always_comb begin
    res_status = ST_DONE;
    res_idx    = '0;
    res_word   = '0;
    wr_en      = 1'b0;
    fill_nxt   = fill_r;
    if (state_r == S_SEL) begin
      unique case (op_r)
        OP_ADD: begin
          priority if (key_r == '0) begin
            res_status = ST_EMPTY;
          end else if (chk_r && hit_any) begin
            res_status = ST_DUP;
            res_idx    = hit_idx;
          end else if (fill_r >= limit) begin
            res_status = ST_FULL;
          end else begin
            wr_en    = 1'b1;
            res_idx  = fill_r[IDX_W-1:0];
            fill_nxt = fill_r + cnt_t'(1);
          end
        end
        OP_FIND: begin
          if (hit_any) begin
            res_idx = hit_idx;
          end else begin
            res_status = ST_MISS;
          end
        end
        OP_READ: begin
          if ({1'b0, slot_r} < fill_r) begin
            res_word = ram_rdata;
          end else begin
            res_status = ST_MISS;
          end
        end
        OP_CLEAR: fill_nxt = '0;
        default:  res_status = ST_DONE;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cap_r       <= cnt_t'(64);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= (state_r == S_SEL);
      if (psel && penable && pwrite && pready && !paddr[ADDR_W-1]) begin
        cap_r <= pwdata[CNT_W-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_operation);
      key_r  <= key_n;
      chk_r  <= in_check_duplicate;
      slot_r <= in_slot;
    end
    if (state_r == S_GRP) begin
      grp_any_r <= grp_any_nxt;
      for (int g = 0; g < NUM_GRP; g++) begin
        grp_idx_r[g] <= grp_idx_nxt[g];
      end
    end
    if (state_r == S_SEL) begin
      out_status_r <= res_status;
      out_idx_r    <= res_idx;
      out_word_r   <= res_word;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_idx_r;
  assign out_word_out    = out_word_r;
  assign out_entry_count = fill_r;

endmodule

### hdl/wtd_checker.sv
// Port-level checks for the word table unit, bound to the top level.
// Depends on wtd_pkg.
`timescale 1ns / 1ps

module wtd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [2:0]                 out_status,
  input logic [wtd_pkg::IDX_W-1:0]  out_found_index,
  input logic [wtd_pkg::KEY_W-1:0]  out_word_out,
  input logic [wtd_pkg::CNT_W-1:0]  out_entry_count
);
  import wtd_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##3 out_valid)
    else $error("result missing three cycles after accept");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_found_index == '0 && out_word_out == '0)
    else $error("empty word result carries data");

endmodule

bind word_table_with_dedup_unit wtd_checker u_wtd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_found_index(out_found_index),
  .out_word_out   (out_word_out),
  .out_entry_count(out_entry_count)
);
